@@ rtl/core/lru_block_cache_manager_core_macros.svh @@
// Assertion macros used by the checker file
`ifndef LRU_BLOCK_CACHE_MANAGER_CORE_MACROS_SVH
`define LRU_BLOCK_CACHE_MANAGER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define LBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/core/lbc_pkg.sv @@
// ---------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes of the LRU block cache directory.
// ---------------------------------------------------------------------------
package lbc_pkg;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned ID_W   = 32;

   typedef enum logic [1:0] {
      KIND_GET    = 2'd0,
      KIND_UPSERT = 2'd1,
      KIND_SYNC   = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] blk_id;
      logic            mark_dirty;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              fill;
      logic              writeback;
      logic [ID_W-1:0]   writeback_id;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } lbc_cmd_type;
endpackage

@@ rtl/core/lru_block_cache_manager_core.sv @@
// ---------------------------------------------------------------------------
// lru_block_cache_manager_core
// Fully associative write-back block cache directory with LRU replacement.
// ---------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | req_data (kind, blk_id, mark_dirty)
//  rsp     | out | rsp_valid/rsp_ready   | rsp_data (status .. writeback_id)
//
//  A request is captured at its transfer edge and executed at the next edge,
//  which loads the response register and raises rsp_valid. With the receiver
//  ready, the next request transfers together with the response; no request
//  is taken while one executes. Reset clears valid and dirty bits and refills
//  the free stack at once. A stalled response holds off the next request.
module lru_block_cache_manager_core #(
   parameter int unsigned SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbc_pkg::rsp_type rsp_data
);
   import lbc_pkg::*;

   lbc_cmd_type cmd;

   lbc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd
   );

   lbc_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .cmd, .req_data, .rsp_data
   );
endmodule

@@ rtl/core/lbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// lbc_ctrl
// Request sequencer: capture, execute, then present the response.
// ---------------------------------------------------------------------------
module lbc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lbc_pkg::lbc_cmd_type cmd
);
   import lbc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RESP} state_type;

   state_type state_ff, state_in;

   // sequence one request at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = req_valid ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // accept a transfer when idle or as the response leaves
   assign req_ready   = (state_ff == ST_IDLE) || (state_ff == ST_RESP && rsp_ready);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC);
endmodule

@@ rtl/core/lbc_datapath.sv @@
// ---------------------------------------------------------------------------
// lbc_datapath
// Tag compare, recency ranks, dirty bits and free stack.
// ---------------------------------------------------------------------------
module lbc_datapath #(
   parameter int unsigned SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbc_pkg::lbc_cmd_type cmd,
   input  lbc_pkg::req_type     req_data,
   output lbc_pkg::rsp_type     rsp_data
);
   import lbc_pkg::*;

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);

   logic [ID_W-1:0] tag_ff [SLOTS];
   logic [IW-1:0]   rank_ff [SLOTS];
   logic [IW-1:0]   stack_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff, dirty_ff;
   logic [CW-1:0]   count_ff;
   req_type         req_ff;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   // lookup and victim search
   logic            found;
   logic [IW-1:0]   found_idx, victim_idx, sel, top_idx;
   logic [IW-1:0]   old_rank;
   logic            use_free;
   always_comb begin
      found = 1'b0; found_idx = '0; victim_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (valid_ff[i] && tag_ff[i] == req_ff.blk_id) begin
            if (!found) found_idx = IW'(i);
            found = 1'b1;
         end
         if (valid_ff[i] && rank_ff[i] == IW'(SLOTS - 1)) victim_idx = IW'(i);
      end
      top_idx  = stack_ff[IW'(count_ff - CW'(1))];
      use_free = (count_ff != '0);
      sel      = found ? found_idx : (use_free ? top_idx : victim_idx);
      old_rank = rank_ff[sel];
   end

   logic is_rm;
   logic dirty_now, evict_wb;
   assign is_rm = (req_ff.kind == KIND_REMOVE);

   // build the response of the held request
   always_comb begin
      dirty_now = found ? dirty_ff[sel] : 1'b0;
      evict_wb  = !found && !use_free && dirty_ff[sel];
      rsp_in    = '0;
      if (is_rm) begin
         if (!found) rsp_in.status = 1'b1;
         else begin
            rsp_in.hit  = 1'b1;
            rsp_in.slot = SLOT_W'(found_idx);
            if (dirty_ff[found_idx]) begin
               rsp_in.writeback    = 1'b1;
               rsp_in.writeback_id = tag_ff[found_idx];
            end
         end
      end else begin
         rsp_in.slot = SLOT_W'(sel);
         rsp_in.hit  = found;
         rsp_in.fill = !found;
         if (evict_wb) begin
            rsp_in.writeback    = 1'b1;
            rsp_in.writeback_id = tag_ff[sel];
         end else if (req_ff.kind == KIND_SYNC && dirty_now) begin
            rsp_in.writeback    = 1'b1;
            rsp_in.writeback_id = req_ff.blk_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         count_ff <= CW'(SLOTS);
         for (int k = 0; k < SLOTS; k++) stack_ff[k] <= IW'(SLOTS - 1 - k);
      end else if (cmd.execute) begin
         rsp_ff <= rsp_in;
         if (is_rm) begin
            if (found) begin
               dirty_ff[found_idx] <= 1'b0;
               valid_ff[found_idx] <= 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (valid_ff[i] && IW'(i) != found_idx && rank_ff[i] > old_rank)
                     rank_ff[i] <= rank_ff[i] - IW'(1);
               if (count_ff < CW'(SLOTS)) begin
                  stack_ff[count_ff[IW-1:0]] <= found_idx;
                  count_ff <= count_ff + CW'(1);
               end
            end
         end else begin
            // rank update: hit moves to front, new entry shifts all others
            for (int i = 0; i < SLOTS; i++)
               if (valid_ff[i] && IW'(i) != sel && (!found || rank_ff[i] < old_rank))
                  rank_ff[i] <= rank_ff[i] + IW'(1);
            rank_ff[sel] <= '0;
            if (!found) begin
               tag_ff[sel]   <= req_ff.blk_id;
               valid_ff[sel] <= 1'b1;
               if (use_free) count_ff <= count_ff - CW'(1);
            end
            if (req_ff.kind == KIND_UPSERT)
               dirty_ff[sel] <= dirty_now | req_ff.mark_dirty;
            else if (req_ff.kind == KIND_SYNC)
               dirty_ff[sel] <= 1'b0;
            else
               dirty_ff[sel] <= dirty_now;
         end
      end
   end

   assign rsp_data = rsp_ff;
endmodule

@@ rtl/core/lbc_checker.sv @@
// ---------------------------------------------------------------------------
// lbc_checker
// Port-level checks of the cache directory.
// ---------------------------------------------------------------------------
`include "lru_block_cache_manager_core_macros.svh"
module lbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lbc_pkg::rsp_type rsp_data
);
   import lbc_pkg::*;
   `LBC_ASSERT_IMPL(a_wb_id_zero, clock, reset, rsp_valid && !rsp_data.writeback, rsp_data.writeback_id == '0, "writeback_id set without writeback")
   `LBC_ASSERT_IMPL(a_fail_clean, clock, reset, rsp_valid && rsp_data.status, !rsp_data.hit && !rsp_data.fill && !rsp_data.writeback, "failed remove carries flags")
   `LBC_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, !rsp_valid, "response too early")
   `LBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")
endmodule

bind lru_block_cache_manager_core lbc_checker u_lbc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
